// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define FSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define FSU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/fsu_pkg.sv -----
// types, constant tables, micro-op program and float arithmetic for the sine unit
`default_nettype none

package fsu_pkg;

  localparam int NVAR   = 22;
  localparam int NCONST = 27;
  localparam int NOP    = 97;

  typedef logic [31:0] fp_t;
  typedef logic [NVAR-1:0][31:0] vars_t;

  typedef enum logic [2:0] {OP_MUL, OP_ADD, OP_SUB, OP_RND, OP_FLR} op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] dst;
    logic [5:0] a;
    logic [5:0] b;
  } instr_t;

  localparam fp_t QNAN = 32'h7fc0_0000;

  // variable slots
  localparam logic [5:0] V_X   = 6'd0;
  localparam logic [5:0] V_XS  = 6'd1;
  localparam logic [5:0] V_XO  = 6'd2;
  localparam logic [5:0] V_N   = 6'd3;
  localparam logic [5:0] V_N0  = 6'd4;
  localparam logic [5:0] V_N1  = 6'd5;
  localparam logic [5:0] V_R   = 6'd6;
  localparam logic [5:0] V_Q   = 6'd7;
  localparam logic [5:0] V_N2  = 6'd8;
  localparam logic [5:0] V_H2  = 6'd9;
  localparam logic [5:0] V_H4  = 6'd10;
  localparam logic [5:0] V_K1  = 6'd11;
  localparam logic [5:0] V_K2  = 6'd12;
  localparam logic [5:0] V_SGN = 6'd13;
  localparam logic [5:0] V_UC  = 6'd14;
  localparam logic [5:0] V_US  = 6'd15;
  localparam logic [5:0] V_Z   = 6'd16;
  localparam logic [5:0] V_SP  = 6'd17;
  localparam logic [5:0] V_CP  = 6'd18;
  localparam logic [5:0] V_T   = 6'd19;
  localparam logic [5:0] V_T2  = 6'd20;
  localparam logic [5:0] V_RES = 6'd21;

  // constant slots, msb set
  localparam logic [5:0] K_INV2048 = 6'd32;
  localparam logic [5:0] K_IHP     = 6'd33;
  localparam logic [5:0] K_C0      = 6'd34;
  localparam logic [5:0] K_C1      = 6'd35;
  localparam logic [5:0] K_C2      = 6'd36;
  localparam logic [5:0] K_P0      = 6'd37;
  localparam logic [5:0] K_P1      = 6'd38;
  localparam logic [5:0] K_P2      = 6'd39;
  localparam logic [5:0] K_P3      = 6'd40;
  localparam logic [5:0] K_P4      = 6'd41;
  localparam logic [5:0] K_P5      = 6'd42;
  localparam logic [5:0] K_P6      = 6'd43;
  localparam logic [5:0] K_2048    = 6'd44;
  localparam logic [5:0] K_HALF    = 6'd45;
  localparam logic [5:0] K_QUARTER = 6'd46;
  localparam logic [5:0] K_M2      = 6'd47;
  localparam logic [5:0] K_FOUR    = 6'd48;
  localparam logic [5:0] K_ONE     = 6'd49;
  localparam logic [5:0] K_M1      = 6'd50;
  localparam logic [5:0] K_S4      = 6'd51;
  localparam logic [5:0] K_S3      = 6'd52;
  localparam logic [5:0] K_S2      = 6'd53;
  localparam logic [5:0] K_S1      = 6'd54;
  localparam logic [5:0] K_CK4     = 6'd55;
  localparam logic [5:0] K_CK3     = 6'd56;
  localparam logic [5:0] K_CK2     = 6'd57;
  localparam logic [5:0] K_CK1     = 6'd58;

  // elaboration-time conversion of a real literal to single precision, nearest even
  function automatic fp_t dbl_to_sgl(input real r);
    logic [63:0] d;
    logic [7:0]  e;
    logic        rup;
    fp_t         res;
    d   = $realtobits(r);
    e   = 8'(int'(d[62:52]) - 896);
    rup = d[28] & ((|d[27:0]) | d[29]);
    res = {d[63], e, d[51:29]};
    res[30:0] = res[30:0] + 31'(rup);
    return res;
  endfunction

  localparam fp_t KTAB [NCONST] = '{
    dbl_to_sgl(0.00048828125),
    dbl_to_sgl(0.63661975),
    dbl_to_sgl(1.5708008),
    dbl_to_sgl(-0.0000044535846),
    dbl_to_sgl(-8.706138e-10),
    dbl_to_sgl(1.5703125),
    dbl_to_sgl(0.0004837513),
    dbl_to_sgl(0.000000075495336),
    dbl_to_sgl(2.5579538e-12),
    dbl_to_sgl(5.389786e-15),
    dbl_to_sgl(5.166901e-19),
    dbl_to_sgl(3.281839e-22),
    dbl_to_sgl(2048.0),
    dbl_to_sgl(0.5),
    dbl_to_sgl(0.25),
    dbl_to_sgl(-2.0),
    dbl_to_sgl(4.0),
    dbl_to_sgl(1.0),
    dbl_to_sgl(-1.0),
    dbl_to_sgl(0.0000027183114939898219064),
    dbl_to_sgl(-0.000198393348360966317347),
    dbl_to_sgl(0.0083333293858894631756),
    dbl_to_sgl(-0.166666666416265235595),
    dbl_to_sgl(0.0000243904487962774090654),
    dbl_to_sgl(-0.00138867637746099294692),
    dbl_to_sgl(0.0416666233237390631894),
    dbl_to_sgl(-0.499999997251031003120)
  };

  // one operation per pipeline stage, dst = op(a, b)
  localparam instr_t PROG [NOP] = '{
    '{OP_MUL, V_XS, V_X,  K_INV2048},
    '{OP_MUL, V_XO, V_XS, K_IHP},
    '{OP_RND, V_N,  V_XO, V_XO},
    '{OP_MUL, V_T,  V_XO, K_INV2048},
    '{OP_RND, V_T,  V_T,  V_T},
    '{OP_MUL, V_N0, V_T,  K_2048},
    '{OP_SUB, V_N1, V_N,  V_N0},
    '{OP_MUL, V_T,  V_N0, K_C0},
    '{OP_SUB, V_R,  V_XS, V_T},
    '{OP_MUL, V_T,  V_N1, K_C0},
    '{OP_SUB, V_R,  V_R,  V_T},
    '{OP_MUL, V_T,  V_N0, K_C1},
    '{OP_SUB, V_R,  V_R,  V_T},
    '{OP_MUL, V_T,  V_N1, K_C1},
    '{OP_SUB, V_R,  V_R,  V_T},
    '{OP_MUL, V_T,  V_N0, K_C2},
    '{OP_SUB, V_R,  V_R,  V_T},
    '{OP_MUL, V_T,  V_R,  K_2048},
    '{OP_MUL, V_Q,  V_T,  K_IHP},
    '{OP_RND, V_N2, V_Q,  V_Q},
    '{OP_MUL, V_N0, V_N0, K_2048},
    '{OP_MUL, V_N1, V_N1, K_2048},
    '{OP_MUL, V_T,  V_N0, K_P0}, '{OP_SUB, V_R, V_X, V_T},
    '{OP_MUL, V_T,  V_N1, K_P0}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N0, K_P1}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P0}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N1, K_P1}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N0, K_P2}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P1}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N1, K_P2}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N0, K_P3}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P2}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N1, K_P3}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N0, K_P4}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P3}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N1, K_P4}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N0, K_P5}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P4}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N1, K_P5}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N0, K_P6}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P5}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N1, K_P6}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,  V_N2, K_P6}, '{OP_SUB, V_R, V_R, V_T},
    '{OP_MUL, V_T,   V_N2, K_HALF},
    '{OP_FLR, V_H2,  V_T,  V_T},
    '{OP_MUL, V_T,   V_N2, K_QUARTER},
    '{OP_FLR, V_H4,  V_T,  V_T},
    '{OP_MUL, V_K1,  V_H2, K_M2},
    '{OP_MUL, V_K2,  V_H4, K_FOUR},
    '{OP_ADD, V_T,   V_K1, V_K2},
    '{OP_ADD, V_SGN, V_T,  K_ONE},
    '{OP_ADD, V_UC,  V_N2, V_K1},
    '{OP_MUL, V_T,   V_UC, K_M1},
    '{OP_ADD, V_US,  V_T,  K_ONE},
    '{OP_MUL, V_Z,   V_R,  V_R},
    '{OP_MUL, V_SP,  V_Z,  K_S4},
    '{OP_ADD, V_T,   V_SP, K_S3},
    '{OP_MUL, V_SP,  V_Z,  V_T},
    '{OP_ADD, V_T,   V_SP, K_S2},
    '{OP_MUL, V_SP,  V_Z,  V_T},
    '{OP_ADD, V_T,   V_SP, K_S1},
    '{OP_MUL, V_SP,  V_Z,  V_T},
    '{OP_ADD, V_T,   V_SP, K_ONE},
    '{OP_MUL, V_SP,  V_R,  V_T},
    '{OP_MUL, V_CP,  V_Z,  K_CK4},
    '{OP_ADD, V_T,   V_CP, K_CK3},
    '{OP_MUL, V_CP,  V_Z,  V_T},
    '{OP_ADD, V_T,   V_CP, K_CK2},
    '{OP_MUL, V_CP,  V_Z,  V_T},
    '{OP_ADD, V_T,   V_CP, K_CK1},
    '{OP_MUL, V_CP,  V_Z,  V_T},
    '{OP_ADD, V_CP,  V_CP, K_ONE},
    '{OP_MUL, V_T,   V_SP, V_US},
    '{OP_MUL, V_T2,  V_CP, V_UC},
    '{OP_ADD, V_RES, V_T,  V_T2},
    '{OP_MUL, V_RES, V_RES, V_SGN}
  };

  // normalize, handle gradual underflow and round to nearest even
  // value is m * 2^(ex - 177); m is nonzero
  function automatic fp_t fp_pack(input logic s, input logic signed [11:0] ex,
                                  input logic [50:0] m);
    logic [5:0]         lz;
    logic [50:0]        mn;
    logic signed [11:0] e;
    logic [11:0]        shamt;
    logic               st;
    logic [7:0]         ef;
    logic               rup;
    logic [30:0]        body;
    fp_t                res;
    lz = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (m[i]) lz = 6'(50 - i);
    end
    mn = m << lz;
    e  = ex - $signed({6'b0, lz});
    ef = 8'd0;
    if (e >= 12'sd255) begin
      res = {s, 8'hff, 23'd0};
    end else begin
      if (e <= 12'sd0) begin
        shamt = 12'(12'sd1 - e);
        if (shamt >= 12'd51) begin
          mn = 51'd1;
        end else begin
          st = |(mn & ~({51{1'b1}} << shamt));
          mn = mn >> shamt;
          mn[0] = mn[0] | st;
        end
      end else begin
        ef = e[7:0];
      end
      rup  = mn[26] & ((|mn[25:0]) | mn[27]);
      body = {ef, mn[49:27]} + 31'(rup);
      res  = {s, body};
    end
    return res;
  endfunction

  function automatic fp_t fp_add(input fp_t a, input fp_t b);
    logic        an, bn, ai, bi, az, bz;
    logic        sx, sy;
    logic [7:0]  ex, ey, exe, eye, d;
    logic [22:0] fx, fy;
    logic [50:0] wx, wy, sh, sum;
    logic        st;
    fp_t         res;
    an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    if (b[30:0] > a[30:0]) begin
      sx = b[31]; ex = b[30:23]; fx = b[22:0];
      sy = a[31]; ey = a[30:23]; fy = a[22:0];
    end else begin
      sx = a[31]; ex = a[30:23]; fx = a[22:0];
      sy = b[31]; ey = b[30:23]; fy = b[22:0];
    end
    exe = (ex == 8'd0) ? 8'd1 : ex;
    eye = (ey == 8'd0) ? 8'd1 : ey;
    d   = exe - eye;
    wx  = {1'b0, (ex != 8'd0), fx, 26'd0};
    wy  = {1'b0, (ey != 8'd0), fy, 26'd0};
    if (d >= 8'd51) begin
      sh = 51'd1;
    end else begin
      st = |(wy & ~({51{1'b1}} << d));
      sh = wy >> d;
      sh[0] = sh[0] | st;
    end
    sum = (sx == sy) ? (wx + sh) : (wx - sh);
    if (an || bn || (ai && bi && (a[31] != b[31]))) res = QNAN;
    else if (ai) res = a;
    else if (bi) res = b;
    else if (az && bz) res = {a[31] & b[31], 31'd0};
    else if (az) res = b;
    else if (bz) res = a;
    else if (sum == 51'd0) res = 32'd0;
    else res = fp_pack(sx, $signed({4'b0, exe}) + 12'sd1, sum);
    return res;
  endfunction

  function automatic fp_t fp_mul(input fp_t a, input fp_t b);
    logic        an, bn, ai, bi, az, bz, s;
    logic [7:0]  eae, ebe;
    logic [47:0] p;
    fp_t         res;
    an  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    bn  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    ai  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    bi  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    az  = (a[30:0] == 31'd0);
    bz  = (b[30:0] == 31'd0);
    s   = a[31] ^ b[31];
    eae = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebe = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p   = {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
    if (an || bn || (ai && bz) || (az && bi)) res = QNAN;
    else if (ai || bi) res = {s, 8'hff, 23'd0};
    else if (az || bz) res = {s, 31'd0};
    else res = fp_pack(s, $signed({4'b0, eae}) + $signed({4'b0, ebe}) - 12'sd123,
                       {3'b0, p});
    return res;
  endfunction

  // round half away from zero, zero keeps the operand's sign
  function automatic fp_t fp_rnd(input fp_t v);
    logic [4:0]  sh;
    logic [30:0] mag;
    fp_t         res;
    sh  = 5'(8'd150 - v[30:23]);
    mag = (v[30:0] + (31'd1 << (sh - 5'd1))) & ~((31'd1 << sh) - 31'd1);
    if (v[30:23] >= 8'd150) res = v;
    else if (v[30:23] < 8'd126) res = {v[31], 31'd0};
    else if (v[30:23] == 8'd126) res = {v[31], 8'd127, 23'd0};
    else res = {v[31], mag};
    return res;
  endfunction

  // round toward minus infinity, zero keeps the operand's sign
  function automatic fp_t fp_flr(input fp_t v);
    logic [4:0]  sh;
    logic [30:0] mask, t;
    fp_t         res;
    sh   = 5'(8'd150 - v[30:23]);
    mask = ~((31'd1 << sh) - 31'd1);
    t    = v[30:0] & mask;
    if (v[31] && ((v[30:0] & ~mask) != 31'd0)) t = t + (31'd1 << sh);
    if (v[30:23] >= 8'd150) res = v;
    else if (v[30:23] < 8'd127) begin
      if (!v[31] || (v[30:0] == 31'd0)) res = {v[31], 31'd0};
      else res = 32'hbf80_0000;
    end else res = {v[31], t};
    return res;
  endfunction

  function automatic fp_t src_val(input vars_t v, input logic [5:0] s);
    return s[5] ? KTAB[s[4:0]] : v[s[4:0]];
  endfunction

  function automatic fp_t fp_exec(input op_t op, input fp_t a, input fp_t b);
    fp_t res;
    unique case (op)
      OP_MUL:  res = fp_mul(a, b);
      OP_ADD:  res = fp_add(a, b);
      OP_SUB:  res = fp_add(a, b ^ 32'h8000_0000);
      OP_RND:  res = fp_rnd(a);
      OP_FLR:  res = fp_flr(a);
      default: res = QNAN;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fsu_stage.sv -----
// one pipeline stage: a single rounded float operation on the carried variables
`default_nettype none

module fsu_stage #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  fsu_pkg::vars_t in_vars,
  output logic          out_valid,
  output fsu_pkg::vars_t out_vars
);
  import fsu_pkg::*;

  localparam instr_t INS = PROG[STEP];

  logic  valid_r;
  vars_t vars_r;
  vars_t vars_nxt;
  fp_t   res;

  always_comb begin
    res      = fp_exec(INS.op, src_val(in_vars, INS.a), src_val(in_vars, INS.b));
    vars_nxt = in_vars;
    vars_nxt[INS.dst[4:0]] = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vars_r <= vars_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vars  = vars_r;

endmodule

`default_nettype wire

// ----- hdl/fp32_sine_unit.sv -----
// single-precision sine: top level with the stage chain and output handshake
//
// usage
//   input channel : in_valid / in_ready / in_x_bits, one IEEE single argument
//   output channel: out_valid / out_ready / out_sine_bits, its sine
//   every float operation is rounded to nearest even in a fixed order;
//   any nan result comes out as the quiet nan 0x7fc00000
// pipeline and throughput
//   97 register stages, one float multiply, add, subtract or integer rounding
//   each, applied in program order from the first stage to the last;
//   one transfer per cycle in each direction while out_ready stays high
// reset
//   synchronous, active low on rst_n; clears every stage's valid bit,
//   data registers are not reset
// stall behavior
//   when the last stage holds a result and out_ready is low the whole chain
//   freezes and in_ready drops; nothing is dropped or repeated, bubbles in
//   the chain still move forward while the output is empty
`default_nettype none

module fp32_sine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sine_bits
);
  import fsu_pkg::*;

  logic [NOP-1:0] stage_valid;
  vars_t          stage_vars [NOP];
  vars_t          init_vars;
  logic           en;
  fp_t            y;

  // chain advances unless the final result is waiting on the receiver
  assign en       = out_ready | ~stage_valid[NOP-1];
  assign in_ready = en;

  // argument enters its slot, all other slots start at zero
  always_comb begin
    init_vars = '0;
    init_vars[V_X[4:0]] = in_x_bits;
  end

  for (genvar g = 0; g < NOP; g++) begin : g_stage
    if (g == 0) begin : g_first
      fsu_stage #(.STEP(g)) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_vars   (init_vars),
        .out_valid (stage_valid[g]),
        .out_vars  (stage_vars[g])
      );
    end else begin : g_rest
      fsu_stage #(.STEP(g)) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stage_valid[g-1]),
        .in_vars   (stage_vars[g-1]),
        .out_valid (stage_valid[g]),
        .out_vars  (stage_vars[g])
      );
    end
  end

  // canonical quiet nan on the way out
  assign y             = stage_vars[NOP-1][V_RES[4:0]];
  assign out_valid     = stage_valid[NOP-1];
  assign out_sine_bits = ((y[30:23] == 8'hff) && (y[22:0] != 23'd0)) ? QNAN : y;

endmodule

`default_nettype wire

// ----- hdl/fsu_checker.sv -----
// port-level checks for the sine unit and their bind
`default_nettype none
`include "assert_macros.svh"

module fsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sine_bits
);

  logic out_stall;
  logic out_nan;

  assign out_stall = out_valid && !out_ready;
  assign out_nan   = out_valid && (out_sine_bits[30:23] == 8'hff) &&
                     (out_sine_bits[22:0] != 23'd0);

  `FSU_ASSERT(a_hold, out_stall |=> out_valid && $stable(out_sine_bits), "result changed in stall")
  `FSU_ASSERT(a_drain, !out_valid |-> in_ready, "input blocked with empty output")
  `FSU_ASSERT(a_backpressure, out_stall |-> !in_ready, "input taken while output stalled")
  `FSU_ASSERT(a_qnan, out_nan |-> out_sine_bits == 32'h7fc00000, "nan not canonical")
  `FSU_ASSERT_RST(a_reset, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind fp32_sine_unit fsu_checker u_fsu_checker (.*);

`default_nettype wire
